>>> src/ptd_pkg.sv
// Shared types and constants for the pulse trigger with dead time block.
// Used by every module under src; depends on nothing else.
package ptd_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_TRIGGER_LEVEL = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_RELEASE_LEVEL = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LEADER_MODE   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_WAIT_BUDGET   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_HOLDOFF_ITEMS = 3'd4;

   localparam logic [15:0] TRIGGER_LEVEL_RESET = 16'd32768;
   localparam logic [15:0] RELEASE_LEVEL_RESET = 16'd16384;
   localparam logic        LEADER_MODE_RESET   = 1'b0;
   localparam logic [15:0] WAIT_BUDGET_RESET   = 16'd3;
   localparam logic [7:0]  HOLDOFF_ITEMS_RESET = 8'd2;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_HOLD = 3'b010,
      PH_WAIT = 3'b100
   } phase_type;

   typedef struct packed {
      logic [15:0] trigger_level;
      logic [15:0] release_level;
      logic        leader_mode;
      logic [15:0] wait_budget;
      logic [7:0]  holdoff_items;
   } cfg_type;

   typedef struct packed {
      logic [11:0] pulse_sample;
      logic [11:0] temp_sample;
      logic        coinc_level;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        event_valid;
      logic [31:0] event_time;
      logic [31:0] event_gap;
      logic [15:0] event_peak;
      logic [15:0] event_temp;
      logic [15:0] budget_left;
      logic        coinc_seen;
      logic        led_drive;
      logic        coinc_drive;
   } rsp_type;

endpackage

>>> src/ptd_csr.sv
// Configuration registers of the pulse trigger block.
// Depends on ptd_pkg for register indexes, reset values and cfg_type.
module ptd_csr
   import ptd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TRIGGER_LEVEL: cfg_in.trigger_level = csr_wdata;
            CSR_RELEASE_LEVEL: cfg_in.release_level = csr_wdata;
            CSR_LEADER_MODE:   cfg_in.leader_mode   = csr_wdata[0];
            CSR_WAIT_BUDGET:   cfg_in.wait_budget   = csr_wdata;
            CSR_HOLDOFF_ITEMS: cfg_in.holdoff_items = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_level <= TRIGGER_LEVEL_RESET;
         cfg_ff.release_level <= RELEASE_LEVEL_RESET;
         cfg_ff.leader_mode   <= LEADER_MODE_RESET;
         cfg_ff.wait_budget   <= WAIT_BUDGET_RESET;
         cfg_ff.holdoff_items <= HOLDOFF_ITEMS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/ptd_input_stage.sv
// Input register of the pulse trigger block: holds one request beat.
// Depends on ptd_pkg for req_type.
module ptd_input_stage
   import ptd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   input  logic    down_ready,
   output logic    item_valid,
   output req_type item_data
);

   logic    vld_ff, vld_in;
   req_type data_ff;

   assign req_stall = vld_ff && !down_ready;
   assign vld_in    = req_stall ? vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = vld_ff;
   assign item_data  = data_ff;

endmodule

>>> src/ptd_core.sv
// Trigger state machine and event record build for one item per cycle, advancing only on fire.
// Depends on ptd_pkg for phase_type, cfg_type, req_type and rsp_type.
module ptd_core
   import ptd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  holdoff_left_ff, holdoff_left_in;
   logic [15:0] budget_count_ff, budget_count_in;
   logic        coinc_latch_ff, coinc_latch_in;
   logic [31:0] trigger_time_ff, trigger_time_in;
   logic [31:0] last_event_time_ff, last_event_time_in;
   logic [11:0] trigger_sample_ff, trigger_sample_in;
   logic [15:0] scaled;
   logic        done;
   logic        busy;

   assign scaled = {item.pulse_sample, 4'b0000};

   always_comb begin
      phase_in           = phase_ff;
      holdoff_left_in    = holdoff_left_ff;
      budget_count_in    = budget_count_ff;
      coinc_latch_in     = coinc_latch_ff;
      trigger_time_in    = trigger_time_ff;
      last_event_time_in = last_event_time_ff;
      trigger_sample_in  = trigger_sample_ff;
      done               = 1'b0;

      case (phase_ff)
         PH_HOLD: begin
            if (holdoff_left_ff != 8'd0) begin
               holdoff_left_in = holdoff_left_ff - 8'd1;
            end
            if (holdoff_left_in == 8'd0) begin
               phase_in = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (scaled > cfg.release_level) begin
               if (cfg.leader_mode && !coinc_latch_ff) begin
                  coinc_latch_in = item.coinc_level;
               end
               if (budget_count_ff == 16'd0) begin
                  done = 1'b1;
               end else begin
                  budget_count_in = budget_count_ff - 16'd1;
               end
            end else begin
               done = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (scaled > cfg.trigger_level) begin
               trigger_time_in   = item.now_ms;
               trigger_sample_in = item.pulse_sample;
               coinc_latch_in    = cfg.leader_mode ? item.coinc_level : 1'b0;
               budget_count_in   = cfg.wait_budget;
               holdoff_left_in   = cfg.holdoff_items;
               phase_in          = (cfg.holdoff_items == 8'd0) ? PH_WAIT : PH_HOLD;
            end
         end
      endcase

      result = '0;
      if (done) begin
         result.event_valid = 1'b1;
         result.event_time  = trigger_time_in;
         result.event_gap   = trigger_time_in - last_event_time_ff;
         result.event_peak  = {trigger_sample_in, 4'b0000};
         result.event_temp  = {item.temp_sample, 4'b0000};
         result.budget_left = budget_count_in;
         result.coinc_seen  = coinc_latch_in;
         last_event_time_in = trigger_time_in;
         phase_in           = PH_IDLE;
      end

      busy               = (phase_in != PH_IDLE);
      result.led_drive   = busy;
      result.coinc_drive = busy && !cfg.leader_mode;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         holdoff_left_ff    <= '0;
         budget_count_ff    <= '0;
         coinc_latch_ff     <= 1'b0;
         trigger_time_ff    <= '0;
         last_event_time_ff <= '0;
         trigger_sample_ff  <= '0;
      end else if (fire) begin
         phase_ff           <= phase_in;
         holdoff_left_ff    <= holdoff_left_in;
         budget_count_ff    <= budget_count_in;
         coinc_latch_ff     <= coinc_latch_in;
         trigger_time_ff    <= trigger_time_in;
         last_event_time_ff <= last_event_time_in;
         trigger_sample_ff  <= trigger_sample_in;
      end
   end

endmodule

>>> src/ptd_output_stage.sv
// Result register of the pulse trigger block: holds one response beat.
// Depends on ptd_pkg for rsp_type.
module ptd_output_stage
   import ptd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    item_valid,
   input  rsp_type result,
   output logic    ready,
   output logic    fire,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   logic    vld_ff, vld_in;
   rsp_type data_ff;

   assign ready  = !vld_ff || !rsp_stall;
   assign fire   = item_valid && ready;
   assign vld_in = ready ? item_valid : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

>>> src/pulse_trigger_with_dead_time_unit.sv
// Pulse trigger with dead time: threshold discriminator over a 12-bit detector
// stream. Each request beat gives exactly one response beat carrying LED and
// follower drive levels, plus an event record when the beat ends an event.
// One beat is taken every cycle while the response side does not stall. The input register
// captures a beat at the edge that takes it; the combinational state update then feeds the
// result register, which captures its response together with the state registers when the
// output stage fires. A stalled response holds the input register and stalls the
// request side in the same cycle. Write configuration only while no beat is in flight.
module pulse_trigger_with_dead_time_unit
   import ptd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  req_type                  req_data,
   output logic                     req_stall,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     rsp_stall,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type cfg;
   logic    item_valid;
   req_type item_data;
   logic    down_ready;
   logic    fire;
   rsp_type result;

   ptd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ptd_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .down_ready (down_ready),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   ptd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (item_data),
      .result (result)
   );

   ptd_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .ready      (down_ready),
      .fire       (fire),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule
